>>> hdl/spq_pkg.sv
// Shared constants, status codes and cell link types for the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue.
package spq_pkg;

  // queue geometry
  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int LEVELS   = 5;

  // field widths
  localparam int LVL_W = 3;
  localparam int TAG_W = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int STS_W = 2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic [LVL_W-1:0]    level;
    logic [TAG_BITS-1:0] tag;
    logic                occupied;  // slot holds an entry
    logic                greater;   // held entry is less urgent than the new one
  } link_t;

  // broadcast command to every cell
  typedef struct packed {
    logic                insert;
    logic                remove;
    logic [LVL_W-1:0]    level;
    logic [TAG_BITS-1:0] tag;
  } cmd_t;

endpackage

>>> hdl/stable_priority_queue.sv
// Top level of the stable priority queue: stream ports, entry count, cell chain, result register.
// Depends on spq_pkg and spq_cell.
//
// A bounded priority queue of 16 entries kept sorted in a chain of cells, head at cell 0.
// An insert (tuser 0) goes in behind every held entry of equal or more urgent level, so equal
// levels leave in arrival order; a level above 4 is stored as 4. A removal (tuser 1) returns
// the head entry. Every word in gives exactly one word out. Inserting into a full queue or
// removing from an empty one is reported in the status and leaves the queue unchanged. All
// cells compare against the new level and shift in the same clock, and the result sits in an
// output register, so one item per cycle is sustained while the output side takes its words.
// The stored entries need no clearing after reset.
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [2:0] level, [18:3] entry_tag, [23:19] zero
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] head_level, [18:3] head_tag, [23:19] occupancy
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int D = spq_pkg::DEPTH;

  logic                         accept;
  logic                         op;
  logic [spq_pkg::LVL_W-1:0]    in_level;
  logic [spq_pkg::LVL_W-1:0]    sat_level;
  logic [spq_pkg::TAG_BITS-1:0] in_tag;
  logic [spq_pkg::CNT_W-1:0]    count;
  logic [spq_pkg::CNT_W-1:0]    count_next;
  logic                         full;
  logic                         empty;
  spq_pkg::cmd_t                cmd;
  spq_pkg::link_t               links [D];
  spq_pkg::link_t               head_link;
  spq_pkg::status_t             status_next;
  logic [spq_pkg::LVL_W-1:0]    out_level;
  logic [spq_pkg::TAG_W-1:0]    out_tag;
  logic [spq_pkg::CNT_W-1:0]    out_count;
  spq_pkg::status_t             out_status;
  logic [spq_pkg::LVL_W-1:0]    res_level_next;
  logic [spq_pkg::TAG_W-1:0]    res_tag_next;

  // input handshake and field unpacking
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = s_tuser;
  assign in_level = s_tdata[2:0];
  assign in_tag   = s_tdata[spq_pkg::TAG_BITS+2:3];

  // out-of-range levels become the least urgent one
  assign sat_level = (in_level >= spq_pkg::LVL_W'(spq_pkg::LEVELS))
                   ? spq_pkg::LVL_W'(spq_pkg::LEVELS - 1) : in_level;

  assign full  = (count == spq_pkg::CNT_W'(D));
  assign empty = (count == '0);

  assign cmd.insert = accept && (op == spq_pkg::OP_INSERT) && !full;
  assign cmd.remove = accept && (op == spq_pkg::OP_REMOVE) && !empty;
  assign cmd.level  = sat_level;
  assign cmd.tag    = in_tag;

  // head cell sees a virtual occupied, not-greater neighbor
  assign head_link.level    = '0;
  assign head_link.tag      = '0;
  assign head_link.occupied = 1'b1;
  assign head_link.greater  = 1'b0;

  // cell chain
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic occ;
    assign occ = (count > spq_pkg::CNT_W'(i));
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occ),
      .left_link  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
      .right_link (links[(i == D - 1) ? i : i + 1]),
      .link       (links[i])
    );
  end

  // next count and result fields
  always_comb begin
    count_next     = count;
    status_next    = spq_pkg::ST_OK;
    res_level_next = '0;
    res_tag_next   = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next     = count - 1'b1;
        res_level_next = links[0].level;
        res_tag_next   = spq_pkg::TAG_W'(links[0].tag);
      end
    end
  end

  // count, output valid and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      out_status <= status_next;
      out_level  <= res_level_next;
      out_tag    <= res_tag_next;
      out_count  <= count_next;
    end
  end

  assign m_tdata = {out_count, out_tag, out_level};
  assign m_tuser = out_status;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(D))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && op == spq_pkg::OP_INSERT && !full) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the queue");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |-> (links[0].level <= links[1].level))
    else $error("head entry less urgent than its successor");

  a_result_count: assert property (@(posedge clk) disable iff (rst)
    accept |=> (m_tdata[23:19] == count))
    else $error("reported occupancy differs from entry count");

endmodule

>>> hdl/spq_cell.sv
// One slot of the sorted cell chain: holds a level and tag, shifts or loads per command.
// Depends on spq_pkg.
module spq_cell (
  input  logic           clk,
  input  spq_pkg::cmd_t  cmd,
  input  logic           occupied,
  input  spq_pkg::link_t left_link,   // neighbor toward the head
  input  spq_pkg::link_t right_link,  // neighbor toward the tail
  output spq_pkg::link_t link
);

  logic [spq_pkg::LVL_W-1:0]    level;
  logic [spq_pkg::TAG_BITS-1:0] tag;
  logic                         greater;

  assign greater = occupied && (level > cmd.level);

  assign link.level    = level;
  assign link.tag      = tag;
  assign link.occupied = occupied;
  assign link.greater  = greater;

  // insert: shift toward tail behind the insertion point, load at it; remove: shift toward head
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (left_link.greater) begin
        level <= left_link.level;
        tag   <= left_link.tag;
      end else if (left_link.occupied && (greater || !occupied)) begin
        level <= cmd.level;
        tag   <= cmd.tag;
      end
    end else if (cmd.remove) begin
      level <= right_link.level;
      tag   <= right_link.tag;
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for stable_priority_queue: directed table, then random insert/remove words.
// Depends on spq_pkg and the stable_priority_queue RTL; keeps its own shadow copy of the queue.
module testbench;

  // one result word as the block reports it
  typedef struct packed {
    spq_pkg::status_t                 status;
    logic [spq_pkg::LVL_W-1:0]        head_level;
    logic [spq_pkg::TAG_W-1:0]        head_tag;
    logic [spq_pkg::CNT_W-1:0]        occupancy;
  } result_t;

  // directed stimulus row; known rows carry a hand-typed result
  typedef struct packed {
    logic                             op;
    logic [spq_pkg::LVL_W-1:0]        level;
    logic [spq_pkg::TAG_W-1:0]        tag;
    logic                             known;
    spq_pkg::status_t                 status;
    logic [spq_pkg::LVL_W-1:0]        head_level;
    logic [spq_pkg::TAG_W-1:0]        head_tag;
    logic [spq_pkg::CNT_W-1:0]        occupancy;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_WORDS  = 1000;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // removal from an empty queue right after reset
    '{spq_pkg::OP_REMOVE, 3'd0, 16'h0000, 1'b1, spq_pkg::ST_EMPTY, 3'd0, 16'h0000, 5'd0},
    // out-of-range level (saturates to 4), most urgent level, equal level after it
    '{spq_pkg::OP_INSERT, 3'd7, 16'hFFFF, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd1},
    '{spq_pkg::OP_INSERT, 3'd0, 16'h0000, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd2},
    '{spq_pkg::OP_INSERT, 3'd4, 16'h1234, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd3},
    // drain: urgent first, then the two level-4 entries in arrival order
    '{spq_pkg::OP_REMOVE, 3'd7, 16'hFFFF, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd2},
    '{spq_pkg::OP_REMOVE, 3'd0, 16'h0000, 1'b1, spq_pkg::ST_OK,    3'd4, 16'hFFFF, 5'd1},
    '{spq_pkg::OP_REMOVE, 3'd0, 16'h0000, 1'b1, spq_pkg::ST_OK,    3'd4, 16'h1234, 5'd0},
    // fill to capacity with mixed levels
    '{spq_pkg::OP_INSERT, 3'd3, 16'hA001, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd1},
    '{spq_pkg::OP_INSERT, 3'd1, 16'h5A02, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd2},
    '{spq_pkg::OP_INSERT, 3'd3, 16'hA003, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd3},
    '{spq_pkg::OP_INSERT, 3'd0, 16'h5A04, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd4},
    '{spq_pkg::OP_INSERT, 3'd2, 16'hA005, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd5},
    '{spq_pkg::OP_INSERT, 3'd5, 16'h5A06, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd6},
    '{spq_pkg::OP_INSERT, 3'd1, 16'hA007, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd7},
    '{spq_pkg::OP_INSERT, 3'd6, 16'h5A08, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd8},
    '{spq_pkg::OP_INSERT, 3'd0, 16'hA009, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd9},
    '{spq_pkg::OP_INSERT, 3'd3, 16'h5A0A, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd10},
    '{spq_pkg::OP_INSERT, 3'd7, 16'hA00B, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd11},
    '{spq_pkg::OP_INSERT, 3'd2, 16'h5A0C, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd12},
    '{spq_pkg::OP_INSERT, 3'd1, 16'hA00D, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd13},
    '{spq_pkg::OP_INSERT, 3'd4, 16'h5A0E, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd14},
    '{spq_pkg::OP_INSERT, 3'd0, 16'hA00F, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd15},
    '{spq_pkg::OP_INSERT, 3'd2, 16'h5A10, 1'b1, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd16},
    // insert into a full queue is refused
    '{spq_pkg::OP_INSERT, 3'd2, 16'hBEEF, 1'b1, spq_pkg::ST_FULL,  3'd0, 16'h0000, 5'd16},
    // head of the full queue, left to the shadow queue
    '{spq_pkg::OP_REMOVE, 3'd5, 16'hC3C3, 1'b0, spq_pkg::ST_OK,    3'd0, 16'h0000, 5'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [2:0] level, [18:3] entry_tag, [23:19] zero
  logic        s_tuser = 1'b0; // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [2:0] head_level, [18:3] head_tag, [23:19] occupancy
  logic [1:0]  m_tuser;        // [1:0] status

  // shadow copy of the queue, head at slot 0
  logic [spq_pkg::LVL_W-1:0] shadow_level [spq_pkg::DEPTH];
  logic [spq_pkg::TAG_W-1:0] shadow_tag [spq_pkg::DEPTH];
  int                        shadow_count = 0;

  result_t pending_results [$];
  logic    row_known = 1'b0;
  result_t row_typed = '0;
  int      src_idle = 28;
  int      sink_idle = 54;
  int      error_count = 0;

  stable_priority_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // apply one word to the shadow queue and return the result it should give
  function automatic result_t admit_or_serve(input logic op,
                                             input logic [spq_pkg::LVL_W-1:0] level,
                                             input logic [spq_pkg::TAG_W-1:0] tag);
    result_t r;
    logic [spq_pkg::LVL_W-1:0] lvl;
    int pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    lvl = (level >= spq_pkg::LEVELS) ? spq_pkg::LVL_W'(spq_pkg::LEVELS - 1) : level;
    if (op == spq_pkg::OP_INSERT) begin
      if (shadow_count >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // behind every entry of equal or more urgent level
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_level[i] > lvl) pos = i;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_level[i] = shadow_level[i-1];
          shadow_tag[i]   = shadow_tag[i-1];
        end
        shadow_level[pos] = lvl;
        shadow_tag[pos]   = tag;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.head_level = shadow_level[0];
      r.head_tag   = shadow_tag[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_level[i-1] = shadow_level[i];
        shadow_tag[i-1]   = shadow_tag[i];
      end
      shadow_count--;
    end
    r.occupancy = spq_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  // offer one word with random gaps ahead; called and returns at a falling edge
  task automatic offer_word(input logic op, input logic [spq_pkg::LVL_W-1:0] level,
                            input logic [spq_pkg::TAG_W-1:0] tag, input logic known,
                            input result_t typed);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tuser   <= op;
    s_tdata   <= {5'b0, tag, level};
    row_known <= known;
    row_typed <= typed;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle);
  end

  // record accepted words, check returned words
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = admit_or_serve(s_tuser, s_tdata[2:0], s_tdata[18:3]);
        if (row_known) want = row_typed;
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.status     = spq_pkg::status_t'(m_tuser);
        got.head_level = m_tdata[2:0];
        got.head_tag   = m_tdata[18:3];
        got.occupancy  = m_tdata[23:19];
        if (pending_results.size() == 0) begin
          $error("result word with none pending: status %0d tdata %h", m_tuser, m_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
          if (got.head_level != want.head_level) begin
            $error("head_level: expected %0d, got %0d", want.head_level, got.head_level);
            error_count++;
          end
          if (got.head_tag != want.head_tag) begin
            $error("head_tag: expected %h, got %h", want.head_tag, got.head_tag);
            error_count++;
          end
          if (got.occupancy != want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            error_count++;
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    result_t typed;
    int insert_pct;
    logic op;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed.status     = DIRECTED[i].status;
      typed.head_level = DIRECTED[i].head_level;
      typed.head_tag   = DIRECTED[i].head_tag;
      typed.occupancy  = DIRECTED[i].occupancy;
      offer_word(DIRECTED[i].op, DIRECTED[i].level, DIRECTED[i].tag, DIRECTED[i].known, typed);
    end

    // random words; insert bias is redrawn every 50 words to swing between empty and full
    insert_pct = 50;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        src_idle  = 54;
        sink_idle = 28;
      end else if (i == 2 * RANDOM_WORDS / 3) begin
        src_idle  = 0;
        sink_idle = 0;
      end
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      op = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
      offer_word(op, spq_pkg::LVL_W'($urandom_range(7)), spq_pkg::TAG_W'($urandom), 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    // drain, then allow for a late stray word
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue.sv
tb/sv/testbench.sv
